### rtl/seir_pkg.sv
`timescale 1ns / 1ps

package seir_pkg;

    // Field widths
    localparam int CMP_W    = 48;   // compartments, Q32.16
    localparam int RATE_W   = 32;   // rates and damping, Q4.28
    localparam int INVN_W   = 48;   // 1/N, Q0.48
    localparam int DT_W     = 32;   // dt, Q8.24
    localparam int FLOW_W   = 64;   // saturated flows and intermediates
    localparam int PROD_W   = 128;  // full 64x64 product
    localparam int HALF_W   = 32;   // multiplier operand width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [FLOW_W-1:0] FLOW_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [CMP_W-1:0]  CMP_MAX  = 48'hFFFF_FFFF_FFFF;

    // Register reset values
    localparam logic [RATE_W-1:0] RST_RATE_INCUBATION = 32'd51539608;   // 0.192
    localparam logic [RATE_W-1:0] RST_RATE_CONTACT    = 32'd469762048;  // 1.75
    localparam logic [RATE_W-1:0] RST_RATE_RECOVERY   = 32'd134217728;  // 0.5
    localparam logic [INVN_W-1:0] RST_INV_POPULATION  = 48'd28147497671; // 1/10000
    localparam logic [DT_W-1:0]   RST_TIME_STEP       = 32'd1677722;    // 0.1

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_INCUBATION = 3'd0,
        CFG_RATE_CONTACT    = 3'd1,
        CFG_RATE_RECOVERY   = 3'd2,
        CFG_INV_POPULATION  = 3'd3,
        CFG_TIME_STEP       = 3'd4
    } seir_cfg_idx_t;

    // Product operations, in issue order
    typedef enum logic [3:0] {
        OP_BEFF = 4'd0,  // beta*damp >> 28
        OP_FRAC = 4'd1,  // S*invN >> 48
        OP_SI   = 4'd2,  // frac*I >> 16
        OP_T1   = 4'd3,  // si*beff >> 28
        OP_INF  = 4'd4,  // t1*dt >> 24
        OP_T2   = 4'd5,  // a*E >> 28
        OP_INC  = 4'd6,  // t2*dt >> 24
        OP_T3   = 4'd7,  // g*I >> 28
        OP_REC  = 4'd8   // t3*dt >> 24
    } seir_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;        // capture accepted request
        seir_op_t   op;          // current product
        logic       mul_en;      // form one partial product
        logic [1:0] mul_part;    // {y half, x half}
        logic       acc_en;      // accumulate registered partial
        logic       acc_clear;   // first partial of a product
        logic       fin_en;      // shift, saturate, store product
        logic       sum_en;      // base + inflow
        logic       settle_en;   // subtract outflow, clamp, publish
        logic       publish_en;  // publish loaded compartments
    } seir_cmd_t;

    typedef struct packed {
        logic              restart;
        logic [RATE_W-1:0] damping_factor;
        logic [CMP_W-1:0]  init_susceptible;
        logic [CMP_W-1:0]  init_exposed;
        logic [CMP_W-1:0]  init_infected;
        logic [CMP_W-1:0]  init_recovered;
    } seir_item_t;

    typedef struct packed {
        logic [CMP_W-1:0] susceptible;
        logic [CMP_W-1:0] exposed;
        logic [CMP_W-1:0] infected;
        logic [CMP_W-1:0] recovered;
        logic             clamped;
    } seir_result_t;

    typedef struct packed {
        logic             clip;
        logic [CMP_W-1:0] value;
    } seir_settle_t;

    // Clamp pos - sub into 0..CMP_MAX
    function automatic seir_settle_t seir_settle(input logic [FLOW_W-1:0] pos,
                                                 input logic [FLOW_W-2:0] sub);
        logic [FLOW_W:0] diff;
        seir_settle_t    res;
        diff = {1'b0, pos} - {2'b00, sub};
        if (diff[FLOW_W]) begin
            res.clip  = 1'b1;
            res.value = '0;
        end else if (|diff[FLOW_W-1:CMP_W]) begin
            res.clip  = 1'b1;
            res.value = CMP_MAX;
        end else begin
            res.clip  = 1'b0;
            res.value = diff[CMP_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/seir_in_if.sv
`timescale 1ns / 1ps

interface seir_in_if;
    import seir_pkg::*;

    logic              valid;
    logic              ready;
    logic              restart;
    logic [RATE_W-1:0] damping_factor;
    logic [CMP_W-1:0]  init_susceptible;
    logic [CMP_W-1:0]  init_exposed;
    logic [CMP_W-1:0]  init_infected;
    logic [CMP_W-1:0]  init_recovered;

    modport source (
        output valid, restart, damping_factor,
               init_susceptible, init_exposed, init_infected, init_recovered,
        input  ready
    );

    modport sink (
        input  valid, restart, damping_factor,
               init_susceptible, init_exposed, init_infected, init_recovered,
        output ready
    );
endinterface

### rtl/seir_out_if.sv
`timescale 1ns / 1ps

interface seir_out_if;
    import seir_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMP_W-1:0] susceptible;
    logic [CMP_W-1:0] exposed;
    logic [CMP_W-1:0] infected;
    logic [CMP_W-1:0] recovered;
    logic             clamped;

    modport source (
        output valid, susceptible, exposed, infected, recovered, clamped,
        input  ready
    );

    modport sink (
        input  valid, susceptible, exposed, infected, recovered, clamped,
        output ready
    );
endinterface

### rtl/seir_cfg_if.sv
`timescale 1ns / 1ps

interface seir_cfg_if;
    import seir_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/seir_ctrl.sv
`timescale 1ns / 1ps

module seir_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_restart,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output seir_pkg::seir_cmd_t cmd
);
    import seir_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SETTLE,
        ST_PUBLISH
    } state_t;

    // Last product cycle: partials 0..3 issue, 1..4 accumulate, 5 finalizes
    localparam logic [2:0] CNT_LAST = 3'd5;

    state_t     state_reg, state_next;
    seir_op_t   op_reg, op_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign accept       = item_valid && item_ready;
    assign out_free     = !out_valid_reg || result_ready;

    // Next op in the issue order
    function automatic seir_op_t next_op(input seir_op_t op);
        seir_op_t nxt;
        case (op)
            OP_BEFF: nxt = OP_FRAC;
            OP_FRAC: nxt = OP_SI;
            OP_SI:   nxt = OP_T1;
            OP_T1:   nxt = OP_INF;
            OP_INF:  nxt = OP_T2;
            OP_T2:   nxt = OP_INC;
            OP_INC:  nxt = OP_T3;
            OP_T3:   nxt = OP_REC;
            default: nxt = OP_BEFF;
        endcase
        return nxt;
    endfunction

    // Sequencing and commands
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.op     = op_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    op_next  = OP_BEFF;
                    cnt_next = '0;
                    state_next = item_restart ? ST_PUBLISH : ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en    = (cnt_reg < 3'd4);
                cmd.mul_part  = cnt_reg[1:0];
                cmd.acc_en    = (cnt_reg >= 3'd1) && (cnt_reg <= 3'd4);
                cmd.acc_clear = (cnt_reg == 3'd1);
                cmd.fin_en    = (cnt_reg == CNT_LAST);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next = '0;
                    if (op_reg == OP_REC)
                        state_next = ST_SUM;
                    else
                        op_next = next_op(op_reg);
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_SETTLE;
            end
            ST_SETTLE:
            begin
                if (out_free)
                begin
                    cmd.settle_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    cmd.publish_en = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Result register valid
        if (cmd.settle_en || cmd.publish_en)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_BEFF;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/seir_datapath.sv
`timescale 1ns / 1ps

module seir_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  seir_pkg::seir_cmd_t            cmd,
    input  seir_pkg::seir_item_t           item_data,
    input  logic                           cfg_write,
    input  logic [seir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [seir_pkg::CFG_DATA_W-1:0] cfg_data,
    output seir_pkg::seir_result_t         result_data
);
    import seir_pkg::*;

    // Configuration
    logic [RATE_W-1:0] rate_inc_reg;
    logic [RATE_W-1:0] rate_con_reg;
    logic [RATE_W-1:0] rate_rec_reg;
    logic [INVN_W-1:0] inv_pop_reg;
    logic [DT_W-1:0]   dt_reg;

    // Model state
    logic [CMP_W-1:0] s_reg, e_reg, i_reg, r_reg;
    logic [CMP_W-1:0] s_next, e_next, i_next, r_next;

    // Step working registers
    logic [RATE_W-1:0] damp_reg;
    logic [FLOW_W-1:0] beff_reg, prod_reg, inf_reg, inc_reg, rec_reg;
    logic [FLOW_W-1:0] pos_s_reg, pos_e_reg, pos_i_reg, pos_r_reg;

    // Shared multiplier
    logic [FLOW_W-1:0] mul_x, mul_y;
    logic [HALF_W-1:0] x_half, y_half;
    logic [FLOW_W-1:0] pp_next, pp_reg;
    logic [1:0]        pp_pos_next, pp_pos_reg;
    logic [PROD_W-1:0] pp_ext;
    logic [PROD_W-1:0] acc_next, acc_reg;
    logic [PROD_W-1:0] shifted;
    logic [FLOW_W-1:0] flow;

    seir_settle_t      set_s, set_e, set_i, set_r;
    seir_result_t      result_reg;

    assign result_data = result_reg;

    // Configuration writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_inc_reg <= RST_RATE_INCUBATION;
            rate_con_reg <= RST_RATE_CONTACT;
            rate_rec_reg <= RST_RATE_RECOVERY;
            inv_pop_reg  <= RST_INV_POPULATION;
            dt_reg       <= RST_TIME_STEP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RATE_INCUBATION: rate_inc_reg <= cfg_data[RATE_W-1:0];
                CFG_RATE_CONTACT:    rate_con_reg <= cfg_data[RATE_W-1:0];
                CFG_RATE_RECOVERY:   rate_rec_reg <= cfg_data[RATE_W-1:0];
                CFG_INV_POPULATION:  inv_pop_reg  <= cfg_data[INVN_W-1:0];
                CFG_TIME_STEP:       dt_reg       <= cfg_data[DT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Operand select per product
    always_comb
    begin
        case (cmd.op)
            OP_BEFF: begin mul_x = {32'd0, rate_con_reg}; mul_y = {32'd0, damp_reg};  end
            OP_FRAC: begin mul_x = {16'd0, s_reg};        mul_y = {16'd0, inv_pop_reg}; end
            OP_SI:   begin mul_x = prod_reg;              mul_y = {16'd0, i_reg};     end
            OP_T1:   begin mul_x = prod_reg;              mul_y = beff_reg;           end
            OP_T2:   begin mul_x = {32'd0, rate_inc_reg}; mul_y = {16'd0, e_reg};     end
            OP_T3:   begin mul_x = {32'd0, rate_rec_reg}; mul_y = {16'd0, i_reg};     end
            default: begin mul_x = prod_reg;              mul_y = {32'd0, dt_reg};    end
        endcase
    end

    // One 32x32 partial product per cycle
    assign x_half      = cmd.mul_part[0] ? mul_x[FLOW_W-1:HALF_W] : mul_x[HALF_W-1:0];
    assign y_half      = cmd.mul_part[1] ? mul_y[FLOW_W-1:HALF_W] : mul_y[HALF_W-1:0];
    assign pp_next     = FLOW_W'(x_half) * FLOW_W'(y_half);
    assign pp_pos_next = {1'b0, cmd.mul_part[0]} + {1'b0, cmd.mul_part[1]};

    // Place the registered partial at its word offset and accumulate
    always_comb
    begin
        case (pp_pos_reg)
            2'd0:    pp_ext = {64'd0, pp_reg};
            2'd1:    pp_ext = {32'd0, pp_reg, 32'd0};
            default: pp_ext = {pp_reg, 64'd0};
        endcase
        acc_next = (cmd.acc_clear ? '0 : acc_reg) + pp_ext;
    end

    // Fixed-point rescale and saturation of the finished product
    always_comb
    begin
        case (cmd.op)
            OP_BEFF, OP_T1, OP_T2, OP_T3: shifted = acc_reg >> 28;
            OP_FRAC:                      shifted = acc_reg >> 48;
            OP_SI:                        shifted = acc_reg >> 16;
            default:                      shifted = acc_reg >> 24;
        endcase
        flow = (|shifted[PROD_W-1:FLOW_W-1]) ? FLOW_MAX : {1'b0, shifted[FLOW_W-2:0]};
    end

    // Outflow and clamp per compartment
    assign set_s = seir_settle(pos_s_reg, inf_reg[FLOW_W-2:0]);
    assign set_e = seir_settle(pos_e_reg, inc_reg[FLOW_W-2:0]);
    assign set_i = seir_settle(pos_i_reg, rec_reg[FLOW_W-2:0]);
    assign set_r = seir_settle(pos_r_reg, '0);

    // Compartment update
    always_comb
    begin
        s_next = s_reg;
        e_next = e_reg;
        i_next = i_reg;
        r_next = r_reg;
        if (cmd.load && item_data.restart)
        begin
            s_next = item_data.init_susceptible;
            e_next = item_data.init_exposed;
            i_next = item_data.init_infected;
            r_next = item_data.init_recovered;
        end
        else if (cmd.settle_en)
        begin
            s_next = set_s.value;
            e_next = set_e.value;
            i_next = set_i.value;
            r_next = set_r.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
            e_reg <= '0;
            i_reg <= '0;
            r_reg <= '0;
        end
        else
        begin
            s_reg <= s_next;
            e_reg <= e_next;
            i_reg <= i_next;
            r_reg <= r_next;
        end
    end

    // Working registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            damp_reg <= item_data.damping_factor;

        if (cmd.mul_en)
        begin
            pp_reg     <= pp_next;
            pp_pos_reg <= pp_pos_next;
        end

        if (cmd.acc_en)
            acc_reg <= acc_next;

        if (cmd.fin_en)
        begin
            case (cmd.op)
                OP_BEFF: beff_reg <= flow;
                OP_INF:  inf_reg  <= flow;
                OP_INC:  inc_reg  <= flow;
                OP_REC:  rec_reg  <= flow;
                default: prod_reg <= flow;
            endcase
        end

        // Inflows added on sum_en, ahead of the outflow subtract on settle_en
        if (cmd.sum_en)
        begin
            pos_s_reg <= {16'd0, s_reg};
            pos_e_reg <= {16'd0, e_reg} + inf_reg;
            pos_i_reg <= {16'd0, i_reg} + inc_reg;
            pos_r_reg <= {16'd0, r_reg} + rec_reg;
        end

        // Result register
        if (cmd.settle_en)
        begin
            result_reg.susceptible <= set_s.value;
            result_reg.exposed     <= set_e.value;
            result_reg.infected    <= set_i.value;
            result_reg.recovered   <= set_r.value;
            result_reg.clamped     <= set_s.clip | set_e.clip | set_i.clip | set_r.clip;
        end
        else if (cmd.publish_en)
        begin
            result_reg.susceptible <= s_reg;
            result_reg.exposed     <= e_reg;
            result_reg.infected    <= i_reg;
            result_reg.recovered   <= r_reg;
            result_reg.clamped     <= 1'b0;
        end
    end

endmodule

### rtl/seir_euler_step_core.sv
`timescale 1ns / 1ps

// SEIR epidemic step engine. Each request on the item channel either loads the
// four compartments S, E, I, R (restart = 1) or advances them by one explicit
// Euler step using the request's damping factor and the rate registers; every
// request yields exactly one result holding the compartments afterwards, with
// clamped set when a new value was clamped to 0 or the 48-bit maximum. In a
// step, nine chained 64x64 products run on a single 32x32 multiplier, each as
// four partial products that are accumulated and then rescaled; then the
// inflows are added and the outflows subtracted and clamped. One request is
// worked on at a time; a new one is accepted as soon as the previous result is
// registered, even while that result still waits on the output. Configuration
// writes are always ready and must be issued only while the block is idle;
// indexes beyond the register list are ignored.
module seir_euler_step_core (
    input  logic        clk,
    input  logic        rst_n,
    seir_in_if.sink     item,
    seir_out_if.source  result,
    seir_cfg_if.sink    cfg
);
    import seir_pkg::*;

    seir_cmd_t    cmd;
    seir_item_t   item_data;
    seir_result_t result_data;
    logic         item_ready;
    logic         result_valid;

    // Request payload
    assign item_data.restart          = item.restart;
    assign item_data.damping_factor   = item.damping_factor;
    assign item_data.init_susceptible = item.init_susceptible;
    assign item_data.init_exposed     = item.init_exposed;
    assign item_data.init_infected    = item.init_infected;
    assign item_data.init_recovered   = item.init_recovered;
    assign item.ready                 = item_ready;

    // Result payload
    assign result.valid       = result_valid;
    assign result.susceptible = result_data.susceptible;
    assign result.exposed     = result_data.exposed;
    assign result.infected    = result_data.infected;
    assign result.recovered   = result_data.recovered;
    assign result.clamped     = result_data.clamped;

    assign cfg.ready = 1'b1;

    seir_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_restart (item.restart),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    seir_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item_data   (item_data),
        .cfg_write   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .result_data (result_data)
    );

endmodule
